>>> sv/tkkm_pkg.sv
// Package for the top-k keep-mask core: shared widths, register map and
// sequencer state type. No dependencies; used by all other files.
package tkkm_pkg;

    // Fixed payload widths
    localparam int unsigned SCORE_W    = 32;
    localparam int unsigned WORD_IDX_W = 4;
    localparam int unsigned KEEP_W     = 11;

    // APB register map: one register at byte 0, address spans two slots
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT = 1'b0;
    localparam logic [KEEP_W-1:0]    KEEP_RESET     = 11'd1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SEL_CHECK,
        ST_SEL_PIV,
        ST_SEL_SCAN,
        ST_SEL_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_THR_RD,
        ST_THR_SET,
        ST_MASK_RD,
        ST_MASK_CMP,
        ST_MASK_EMIT
    } state_t;

endpackage

>>> sv/tkkm_in_if.sv
// Input channel interface: one score per transaction plus end-of-set flag.
// Depends on tkkm_pkg.
interface tkkm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tkkm_pkg::SCORE_W-1:0] score;
    logic                                last;

    modport source (output valid, output score, output last, input ready);
    modport sink   (input valid, input score, input last, output ready);
endinterface

>>> sv/tkkm_out_if.sv
// Output channel interface: one keep-mask word per transaction.
// Depends on tkkm_pkg.
interface tkkm_out_if #(
    parameter int MASK_WORD_BITS = 64
);
    logic                              valid;
    logic                              ready;
    logic [MASK_WORD_BITS-1:0]         mask_bits;
    logic [tkkm_pkg::WORD_IDX_W-1:0]   word_index;
    logic                              last_word;

    modport source (output valid, output mask_bits, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input mask_bits, input word_index,
                    input last_word, output ready);
endinterface

>>> sv/top_k_keep_mask_core.sv
// Top level of the top-k keep-mask core: score and work memories, the
// quickselect / mask sequencer and its shared signed comparator.
// Depends on tkkm_pkg, tkkm_in_if, tkkm_out_if and tkkm_apb_cfg.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-------------------------------
//   in_ch    | sink      | valid / ready    | score[31:0] signed, last
//   out_ch   | source    | valid / ready    | mask_bits, word_index, last_word
//   apb      | slave     | psel/penable/pready | keep_count at byte 0
//
// Accepts one score per cycle while loading. After last: the scores are
// copied to the work memory, then quickselect takes about 2n..3.4n
// compares (quadratic on ordered sets), and the mask pass sets one bit
// per score and pads the last word with zeros. Copy and selection are
// skipped for keep_count zero. in_ch.ready is low from last until the final
// mask word is in the output register; a held output word stalls the
// sequencer. Reset clears control only; the memories need no clearing pass.
module top_k_keep_mask_core #(
    parameter int MAX_SCORES     = 1024,
    parameter int MASK_WORD_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tkkm_in_if.sink                           in_ch,
    tkkm_out_if.source                        out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tkkm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tkkm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tkkm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CW  = $clog2(MAX_SCORES + 1);
    localparam int IW  = $clog2(MAX_SCORES);
    localparam int SW  = $clog2(MAX_SCORES + MASK_WORD_BITS);
    localparam int BW  = $clog2(MASK_WORD_BITS);
    localparam int KW2 = (CW > tkkm_pkg::KEEP_W) ? CW : tkkm_pkg::KEEP_W;
    localparam int DW  = tkkm_pkg::SCORE_W;
    localparam int XW  = tkkm_pkg::WORD_IDX_W;

    // Configuration
    logic [tkkm_pkg::KEEP_W-1:0] keep_count;

    tkkm_apb_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .keep_count (keep_count)
    );

    // Sequencer registers
    tkkm_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       n_reg, n_next;
    logic                keep_any_reg, keep_any_next;
    logic [IW-1:0]       t_reg, t_next;
    logic [IW-1:0]       lo_reg, lo_next;
    logic [IW-1:0]       hi_reg, hi_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       j_reg, j_next;
    logic signed [DW-1:0] pv_reg, pv_next;
    logic signed [DW-1:0] hold_reg, hold_next;
    logic signed [DW-1:0] thr_reg, thr_next;
    logic [SW-1:0]       scan_reg, scan_next;
    logic [BW-1:0]       bit_reg, bit_next;
    logic [MASK_WORD_BITS-1:0] word_reg, word_next;
    logic [XW-1:0]       wcnt_reg, wcnt_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [MASK_WORD_BITS-1:0] out_mask_reg, out_mask_next;
    logic [XW-1:0]             out_idx_reg, out_idx_next;
    logic                      out_last_reg, out_last_next;

    // Memory ports
    logic signed [DW-1:0] score_mem [MAX_SCORES];
    logic signed [DW-1:0] work_mem  [MAX_SCORES];
    logic                 score_we, score_re, work_we, work_re;
    logic [IW-1:0]        score_waddr, score_raddr, work_waddr, work_raddr;
    logic signed [DW-1:0] score_wdata, work_wdata;
    logic signed [DW-1:0] score_rdata_reg, work_rdata_reg;

    // Shared comparator and helpers
    logic signed [DW-1:0] cmp_x, cmp_y;
    logic                 cmp_le;
    logic                 in_acc;
    logic [CW-1:0]        n_load;
    logic [KW2-1:0]       k_sat;
    logic                 emit_go;
    logic                 scan_done;
    logic                 word_full;

    assign cmp_x  = (state_reg == tkkm_pkg::ST_MASK_CMP) ? thr_reg : work_rdata_reg;
    assign cmp_y  = (state_reg == tkkm_pkg::ST_MASK_CMP) ? score_rdata_reg : pv_reg;
    assign cmp_le = (cmp_x <= cmp_y);

    assign in_ch.ready = (state_reg == tkkm_pkg::ST_LOAD);
    assign in_acc      = in_ch.valid & in_ch.ready;

    // Set size after this transaction, and saturated keep count
    assign n_load = (count_reg < CW'(MAX_SCORES)) ? count_reg + CW'(1) : count_reg;
    assign k_sat  = (KW2'(keep_count) > KW2'(n_load)) ? KW2'(n_load) : KW2'(keep_count);

    assign emit_go   = !out_valid_reg || out_ch.ready;
    assign scan_done = (scan_reg >= SW'(n_reg));
    assign word_full = (bit_reg == BW'(MASK_WORD_BITS - 1));

    // Memories: one write and one registered read each per cycle
    always_ff @(posedge clk)
    begin
        if (score_we)
        begin
            score_mem[score_waddr] <= score_wdata;
        end
        if (score_re)
        begin
            score_rdata_reg <= score_mem[score_raddr];
        end
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (work_re)
        begin
            work_rdata_reg <= work_mem[work_raddr];
        end
    end

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        keep_any_next  = keep_any_reg;
        t_next         = t_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pv_next        = pv_reg;
        hold_next      = hold_reg;
        thr_next       = thr_reg;
        scan_next      = scan_reg;
        bit_next       = bit_reg;
        word_next      = word_reg;
        wcnt_next      = wcnt_reg;
        out_valid_next = out_valid_reg & ~out_ch.ready;
        out_mask_next  = out_mask_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;

        score_we    = 1'b0;
        score_waddr = count_reg[IW-1:0];
        score_wdata = in_ch.score;
        score_re    = 1'b0;
        score_raddr = scan_reg[IW-1:0];
        work_we     = 1'b0;
        work_waddr  = i_reg;
        work_wdata  = hold_reg;
        work_re     = 1'b0;
        work_raddr  = j_reg;

        unique case (state_reg)
            // Store scores; last starts the selection, or the mask pass for keep_count zero
            tkkm_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CW'(MAX_SCORES))
                    begin
                        score_we = 1'b1;
                    end
                    count_next = n_load;
                    if (in_ch.last)
                    begin
                        n_next        = n_load;
                        keep_any_next = (k_sat != '0);
                        t_next        = IW'(KW2'(n_load) - k_sat);
                        lo_next       = '0;
                        hi_next       = IW'(n_load - CW'(1));
                        scan_next     = '0;
                        bit_next      = '0;
                        wcnt_next     = '0;
                        state_next    = (k_sat != '0) ? tkkm_pkg::ST_COPY_RD
                                                      : tkkm_pkg::ST_MASK_RD;
                    end
                end
            end

            // Copy score memory into work memory
            tkkm_pkg::ST_COPY_RD:
            begin
                score_re   = 1'b1;
                state_next = tkkm_pkg::ST_COPY_WR;
            end

            tkkm_pkg::ST_COPY_WR:
            begin
                work_we    = 1'b1;
                work_waddr = scan_reg[IW-1:0];
                work_wdata = score_rdata_reg;
                if (scan_reg + SW'(1) >= SW'(n_reg))
                begin
                    state_next = tkkm_pkg::ST_SEL_CHECK;
                end
                else
                begin
                    scan_next  = scan_reg + SW'(1);
                    state_next = tkkm_pkg::ST_COPY_RD;
                end
            end

            // Range check, fetch pivot from the top of the range
            tkkm_pkg::ST_SEL_CHECK:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = tkkm_pkg::ST_THR_RD;
                end
                else
                begin
                    work_re    = 1'b1;
                    work_raddr = hi_reg;
                    state_next = tkkm_pkg::ST_SEL_PIV;
                end
            end

            tkkm_pkg::ST_SEL_PIV:
            begin
                pv_next    = work_rdata_reg;
                i_next     = lo_reg;
                j_next     = lo_reg;
                state_next = tkkm_pkg::ST_SEL_SCAN;
            end

            // Lomuto scan: read element j, or finish at the pivot
            tkkm_pkg::ST_SEL_SCAN:
            begin
                work_re = 1'b1;
                if (j_reg == hi_reg)
                begin
                    work_raddr = i_reg;
                    state_next = tkkm_pkg::ST_FIN_RD;
                end
                else
                begin
                    work_raddr = j_reg;
                    state_next = tkkm_pkg::ST_SEL_CMP;
                end
            end

            tkkm_pkg::ST_SEL_CMP:
            begin
                hold_next = work_rdata_reg;
                if (cmp_le && i_reg != j_reg)
                begin
                    work_re    = 1'b1;
                    work_raddr = i_reg;
                    state_next = tkkm_pkg::ST_SWAP_RD;
                end
                else
                begin
                    if (cmp_le)
                    begin
                        i_next = i_reg + IW'(1);
                    end
                    j_next     = j_reg + IW'(1);
                    state_next = tkkm_pkg::ST_SEL_SCAN;
                end
            end

            // Swap elements i and j through the hold register
            tkkm_pkg::ST_SWAP_RD:
            begin
                work_we    = 1'b1;
                work_waddr = i_reg;
                work_wdata = hold_reg;
                hold_next  = work_rdata_reg;
                state_next = tkkm_pkg::ST_SWAP_WR;
            end

            tkkm_pkg::ST_SWAP_WR:
            begin
                work_we    = 1'b1;
                work_waddr = j_reg;
                work_wdata = hold_reg;
                i_next     = i_reg + IW'(1);
                j_next     = j_reg + IW'(1);
                state_next = tkkm_pkg::ST_SEL_SCAN;
            end

            // Place the pivot at i, then narrow the range or finish at rank t
            tkkm_pkg::ST_FIN_RD:
            begin
                work_we    = 1'b1;
                work_waddr = i_reg;
                work_wdata = pv_reg;
                hold_next  = work_rdata_reg;
                state_next = tkkm_pkg::ST_FIN_WR;
            end

            tkkm_pkg::ST_FIN_WR:
            begin
                work_we    = 1'b1;
                work_waddr = hi_reg;
                work_wdata = hold_reg;
                if (i_reg == t_reg)
                begin
                    state_next = tkkm_pkg::ST_THR_RD;
                end
                else
                begin
                    if (t_reg < i_reg)
                    begin
                        hi_next = i_reg - IW'(1);
                    end
                    else
                    begin
                        lo_next = i_reg + IW'(1);
                    end
                    state_next = tkkm_pkg::ST_SEL_CHECK;
                end
            end

            // Threshold is the element at rank t
            tkkm_pkg::ST_THR_RD:
            begin
                work_re    = 1'b1;
                work_raddr = t_reg;
                state_next = tkkm_pkg::ST_THR_SET;
            end

            tkkm_pkg::ST_THR_SET:
            begin
                thr_next   = work_rdata_reg;
                scan_next  = '0;
                state_next = tkkm_pkg::ST_MASK_RD;
            end

            // Mask pass: one score per bit, padded with zeros past n
            tkkm_pkg::ST_MASK_RD:
            begin
                if (!scan_done)
                begin
                    score_re   = 1'b1;
                    state_next = tkkm_pkg::ST_MASK_CMP;
                end
                else
                begin
                    word_next = {1'b0, word_reg[MASK_WORD_BITS-1:1]};
                    scan_next = scan_reg + SW'(1);
                    bit_next  = word_full ? '0 : bit_reg + BW'(1);
                    state_next = word_full ? tkkm_pkg::ST_MASK_EMIT
                                           : tkkm_pkg::ST_MASK_RD;
                end
            end

            tkkm_pkg::ST_MASK_CMP:
            begin
                word_next  = {keep_any_reg & cmp_le, word_reg[MASK_WORD_BITS-1:1]};
                scan_next  = scan_reg + SW'(1);
                bit_next   = word_full ? '0 : bit_reg + BW'(1);
                state_next = word_full ? tkkm_pkg::ST_MASK_EMIT : tkkm_pkg::ST_MASK_RD;
            end

            // Hand the word to the output register
            tkkm_pkg::ST_MASK_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_mask_next  = word_reg;
                    out_idx_next   = wcnt_reg;
                    out_last_next  = scan_done;
                    wcnt_next      = wcnt_reg + XW'(1);
                    if (scan_done)
                    begin
                        count_next = '0;
                        state_next = tkkm_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = tkkm_pkg::ST_MASK_RD;
                    end
                end
            end

            default:
            begin
                state_next = tkkm_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkkm_pkg::ST_LOAD;
            count_reg     <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        keep_any_reg <= keep_any_next;
        t_reg        <= t_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pv_reg       <= pv_next;
        hold_reg     <= hold_next;
        scan_reg     <= scan_next;
        bit_reg      <= bit_next;
        word_reg     <= word_next;
        wcnt_reg     <= wcnt_next;
        out_mask_reg <= out_mask_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mask_bits  = out_mask_reg;
    assign out_ch.word_index = out_idx_reg;
    assign out_ch.last_word  = out_last_reg;

    // Partition scan never runs past the pivot slot
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tkkm_pkg::ST_SEL_CMP) |-> (j_reg < hi_reg && i_reg <= j_reg))
        else $error("partition indices out of range");

    // The final mask word returns the block to loading with an empty set
    a_last_word_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tkkm_pkg::ST_MASK_EMIT && emit_go && scan_done)
        |=> (state_reg == tkkm_pkg::ST_LOAD && count_reg == '0 && out_last_reg))
        else $error("last mask word did not end the set");

    // Threshold only changes on its own load step
    a_thr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tkkm_pkg::ST_THR_SET) |=> $stable(thr_reg))
        else $error("threshold changed outside selection end");

endmodule

>>> sv/tkkm_apb_cfg.sv
// APB configuration register file: holds keep_count.
// Depends on tkkm_pkg.
module tkkm_apb_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tkkm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tkkm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tkkm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [tkkm_pkg::KEEP_W-1:0]       keep_count
);

    logic [tkkm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;
    logic [tkkm_pkg::KEEP_W-1:0]    keep_count_reg;
    logic [tkkm_pkg::KEEP_W-1:0]    keep_count_next;

    // Word-aligned register index
    assign reg_idx = paddr[tkkm_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    // Write decode
    always_comb
    begin
        keep_count_next = keep_count_reg;
        if (wr_en && reg_idx == tkkm_pkg::REG_KEEP_COUNT)
        begin
            keep_count_next = pwdata[tkkm_pkg::KEEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= tkkm_pkg::KEEP_RESET;
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        if (reg_idx == tkkm_pkg::REG_KEEP_COUNT)
        begin
            prdata = tkkm_pkg::APB_DATA_W'(keep_count_reg);
        end
    end

    assign keep_count = keep_count_reg;

endmodule
